// File: rtl/core/self_organizing_array_table_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef SELF_ORGANIZING_ARRAY_TABLE_TOP_MACROS_SVH
`define SELF_ORGANIZING_ARRAY_TABLE_TOP_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SOTAB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sotab: same-cycle property violated");

// Consequent in the cycle after the antecedent.
`define SOTAB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sotab: next-cycle property violated");

`define SOTAB_ASSERT_LATER2(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
        else $error("sotab: two-cycle property violated");

`endif

// File: rtl/core/sotab_pkg.sv
package sotab_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int WORD_WIDTH_DEF  = 32;

    // fixed field widths on the ports
    localparam int CMD_W     = 2;
    localparam int POS_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int HIT_W     = 5;
    localparam int COUNT_W   = 6;
    localparam int POLICY_W  = 2;
    localparam int CAP_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 6;

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_PLAIN     = 2'd0,
        POL_TRANSPOSE = 2'd1,
        POL_FRONT     = 2'd2,
        POL_UNUSED    = 2'd3
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY   = 1'b0,
        CFG_CAPACITY = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_DELETE = 3'd3,
        CELL_SWAP   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     swap_front;
        logic     match_en;
    } cell_ctrl_t;

endpackage

// File: rtl/core/sotab_cell.sv
module sotab_cell #(
    parameter int INDEX       = 0,
    parameter int CNT_W       = 6,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sotab_pkg::cell_ctrl_t  cell_ctrl,
    input  logic [CNT_W-1:0]       op_pos,
    input  logic [CNT_W-1:0]       op_count,
    input  logic [CNT_W-1:0]       op_hit,
    input  logic [WORD_WIDTH-1:0]  new_word,
    input  logic [WORD_WIDTH-1:0]  key_word,
    input  logic [WORD_WIDTH-1:0]  left_word,
    input  logic [WORD_WIDTH-1:0]  right_word,
    input  logic [WORD_WIDTH-1:0]  front_word,
    input  logic [WORD_WIDTH-1:0]  sel_word,
    output logic [WORD_WIDTH-1:0]  entry_word,
    output logic                   match
);
    import sotab_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_N1 = CNT_W'(INDEX + 1);

    logic [WORD_WIDTH-1:0] entry_reg, entry_next;
    logic                  match_reg;
    logic [CNT_W-1:0]      dst;

    assign dst = cell_ctrl.swap_front ? '0 : (op_hit - 1'b1);

    always_comb begin
        entry_next = entry_reg;
        case (cell_ctrl.op)
            CELL_APPEND: begin
                if (IDX_C == op_count) entry_next = new_word;
            end
            CELL_INSERT: begin
                if (IDX_C == op_pos) begin
                    entry_next = new_word;
                end else if (IDX_C > op_pos && IDX_C <= op_count) begin
                    entry_next = left_word;
                end
            end
            CELL_DELETE: begin
                if (IDX_C >= op_pos && IDX_N1 < op_count) entry_next = right_word;
            end
            CELL_SWAP: begin
                if (IDX_C == dst) begin
                    entry_next = sel_word;
                end else if (IDX_C == op_hit) begin
                    entry_next = cell_ctrl.swap_front ? front_word : left_word;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    // entry is payload: no reset, never read before written
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (cell_ctrl.match_en) begin
            match_reg <= (entry_reg == key_word) && (IDX_C < op_count);
        end
    end

    assign entry_word = entry_reg;
    assign match      = match_reg;

endmodule

// File: rtl/core/sotab_ctrl.sv
module sotab_ctrl #(
    parameter int TABLE_DEPTH = sotab_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_WIDTH  = sotab_pkg::WORD_WIDTH_DEF,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config
    input  logic                           cfg_wr_en,
    input  logic [sotab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sotab_pkg::CFG_DAT_W-1:0] cfg_wdata,
    // command side
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sotab_pkg::CMD_W-1:0]    in_cmd,
    input  logic [sotab_pkg::POS_W-1:0]    in_pos,
    input  logic [WORD_WIDTH-1:0]          in_word,
    // cell row
    output sotab_pkg::cell_ctrl_t          cell_ctrl,
    output logic [CNT_W-1:0]               op_pos,
    output logic [CNT_W-1:0]               op_count,
    output logic [CNT_W-1:0]               op_hit,
    output logic [WORD_WIDTH-1:0]          op_word,
    output logic [WORD_WIDTH-1:0]          sel_word,
    input  logic [TABLE_DEPTH-1:0]         match_vec,
    input  logic [WORD_WIDTH-1:0]          entry_words [TABLE_DEPTH],
    // result side
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sotab_pkg::STATUS_W-1:0] out_status,
    output logic [sotab_pkg::HIT_W-1:0]    out_hit,
    output logic [sotab_pkg::VALUE_W-1:0]  out_removed,
    output logic [sotab_pkg::COUNT_W-1:0]  out_count
);
    import sotab_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [POLICY_W-1:0]   policy_reg;
    logic [CAP_W-1:0]      cap_reg;
    cmd_t                  cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] word_reg;

    logic                  out_valid_reg;
    status_t               status_reg, status_next;
    logic [HIT_W-1:0]      hit_reg, hit_next;
    logic [VALUE_W-1:0]    removed_reg, removed_next;
    logic [COUNT_W-1:0]    cnt_out_reg;

    logic                  accept, exec_go, found, full;
    logic [IDX_W-1:0]      hit_idx, sel_idx;
    logic [CMP_W-1:0]      pos_c, cnt_c, lim_c, cap_c;
    cell_op_t              op_next;
    logic                  swap_front;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // first match over the registered compare results
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign sel_idx  = (cmd_reg == CMD_DELETE) ? IDX_W'(pos_reg) : hit_idx;
    assign sel_word = entry_words[sel_idx];

    assign pos_c = CMP_W'(pos_reg);
    assign cnt_c = CMP_W'(count_reg);
    assign lim_c = CMP_W'(cap_reg);
    assign cap_c = (lim_c > DEPTH_C) ? DEPTH_C : lim_c;
    assign full  = (cnt_c >= cap_c);

    always_comb begin
        status_next  = ST_OK;
        hit_next     = '0;
        removed_next = '0;
        count_next   = count_reg;
        op_next      = CELL_HOLD;
        swap_front   = 1'b0;
        case (cmd_reg)
            CMD_APPEND: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op_next    = CELL_APPEND;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_c > cnt_c) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op_next    = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (pos_c >= cnt_c) begin
                    status_next = ST_RANGE;
                end else begin
                    op_next      = CELL_DELETE;
                    removed_next = VALUE_W'(sel_word);
                    count_next   = count_reg - 1'b1;
                end
            end
            CMD_SEARCH: begin
                if (!found) begin
                    status_next = ST_NOT_FOUND;
                end else begin
                    hit_next = HIT_W'(hit_idx);
                    if (hit_idx != '0) begin
                        if (policy_reg == POL_TRANSPOSE) begin
                            op_next = CELL_SWAP;
                        end else if (policy_reg == POL_FRONT) begin
                            op_next    = CELL_SWAP;
                            swap_front = 1'b1;
                        end
                    end
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept)  state_next = S_EXEC;
            S_EXEC:  if (exec_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            policy_reg    <= POL_PLAIN;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_go) count_reg <= count_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_POLICY:   policy_reg <= cfg_wdata[POLICY_W-1:0];
                    CFG_CAPACITY: cap_reg    <= cfg_wdata[CAP_W-1:0];
                    default:      policy_reg <= policy_reg;
                endcase
            end
            if (exec_go) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cmd_t'(in_cmd);
            pos_reg  <= in_pos;
            word_reg <= in_word;
        end
        if (exec_go) begin
            status_reg  <= status_next;
            hit_reg     <= hit_next;
            removed_reg <= removed_next;
            cnt_out_reg <= COUNT_W'(count_next);
        end
    end

    always_comb begin
        cell_ctrl.op         = exec_go ? op_next : CELL_HOLD;
        cell_ctrl.swap_front = swap_front;
        cell_ctrl.match_en   = accept;
    end

    assign op_pos   = CNT_W'(pos_reg);
    assign op_count = count_reg;
    assign op_hit   = CNT_W'(hit_idx);
    assign op_word  = word_reg;

    assign out_valid   = out_valid_reg;
    assign out_status  = status_reg;
    assign out_hit     = hit_reg;
    assign out_removed = removed_reg;
    assign out_count   = cnt_out_reg;

endmodule

// File: rtl/core/self_organizing_array_table_top.sv
// Self-organising table: a row of word cells under one command sequencer.
// The result beat is loaded in S_EXEC after the accepting edge: the compare is
// registered on the accepting edge and the update follows; a stall on m_tready delays it.
// Commands do not overlap: s_tready is low in S_EXEC, after the registered parallel
// compare in each cell, for the find-first and shift/swap step across the row.
// Reset: aresetn synchronous, active low; clears count, policy (plain), capacity (32).
module self_organizing_array_table_top #(
    parameter int TABLE_DEPTH = sotab_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_WIDTH  = sotab_pkg::WORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [sotab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sotab_pkg::CFG_DAT_W-1:0] cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sotab_pkg::S_DATA_W-1:0]  s_tdata,  // position_in[5:0], new_value[37:6],
                                                      // search_key[69:38], zero pad
    input  logic [sotab_pkg::S_USER_W-1:0]  s_tuser,  // cmd[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sotab_pkg::M_DATA_W-1:0]  m_tdata   // status[1:0], hit_position[6:2],
                                                      // removed_value[38:7],
                                                      // entry_count[44:39], zero pad
);
    import sotab_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // command beat fields
    logic [POS_W-1:0]      in_pos;
    logic [WORD_WIDTH-1:0] in_word;
    logic [WORD_WIDTH-1:0] key_word;

    // size cast of a signed value sign-extends or truncates to the word
    assign in_pos   = s_tdata[5:0];
    assign in_word  = WORD_WIDTH'($signed(s_tdata[37:6]));
    assign key_word = WORD_WIDTH'($signed(s_tdata[69:38]));

    // sequencer <-> cell row
    cell_ctrl_t            cell_ctrl;
    logic [CNT_W-1:0]      op_pos, op_count, op_hit;
    logic [WORD_WIDTH-1:0] op_word, sel_word;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [WORD_WIDTH-1:0] entry_words [TABLE_DEPTH];

    // result beat fields
    logic [STATUS_W-1:0]   out_status;
    logic [HIT_W-1:0]      out_hit;
    logic [VALUE_W-1:0]    out_removed;
    logic [COUNT_W-1:0]    out_count;

    sotab_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_pos      (in_pos),
        .in_word     (in_word),
        .cell_ctrl   (cell_ctrl),
        .op_pos      (op_pos),
        .op_count    (op_count),
        .op_hit      (op_hit),
        .op_word     (op_word),
        .sel_word    (sel_word),
        .match_vec   (match_vec),
        .entry_words (entry_words),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_hit     (out_hit),
        .out_removed (out_removed),
        .out_count   (out_count)
    );

    // Cell row: each cell holds one entry, compares it against the key on the
    // accept edge and takes its neighbour's word on insert/delete shifts.
    // The row ends see zeros; those inputs are never selected there.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_w, right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = entry_words[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = entry_words[i+1];
        end

        sotab_cell #(
            .INDEX      (i),
            .CNT_W      (CNT_W),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_ctrl  (cell_ctrl),
            .op_pos     (op_pos),
            .op_count   (op_count),
            .op_hit     (op_hit),
            .new_word   (op_word),
            .key_word   (key_word),
            .left_word  (left_w),
            .right_word (right_w),
            .front_word (entry_words[0]),
            .sel_word   (sel_word),
            .entry_word (entry_words[i]),
            .match      (match_vec[i])
        );
    end

    assign m_tdata = {3'b000, out_count, out_removed, out_hit, out_status};

endmodule

// File: rtl/core/sotab_checker.sv
`include "self_organizing_array_table_top_macros.svh"

module sotab_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sotab_pkg::M_DATA_W-1:0]  m_tdata
);
    import sotab_pkg::*;

    logic s_beat;
    logic failed;

    assign s_beat = s_tvalid && s_tready;
    assign failed = (m_tdata[1:0] != ST_OK);

    // one command in flight: s_tready drops in the cycle after an accepted beat
    `SOTAB_ASSERT_NEXT(a_no_back_to_back, aclk, aresetn, s_beat, !s_tready)

    // every accepted command is followed by a pending result beat
    `SOTAB_ASSERT_LATER2(a_result_follows, aclk, aresetn, s_beat, m_tvalid)

    // a rejected command reports neither a hit position nor a removed word
    `SOTAB_ASSERT_NOW(a_fail_fields_zero, aclk, aresetn, m_tvalid && failed,
                      (m_tdata[6:2] == '0) && (m_tdata[38:7] == '0))

    // stalled result beat holds
    `SOTAB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                       m_tvalid && $stable(m_tdata))

endmodule

bind self_organizing_array_table_top sotab_checker u_sotab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
